// File: sv/sps_pkg.sv
// sps_pkg: request and response types, action and status codes for the
// shortest path search block. No dependencies.
`default_nettype none
package sps_pkg;

	localparam int NODE_ID_W = 6;
	localparam int WEIGHT_W  = 24;
	localparam int OUT_DIST_W = 32;
	localparam int MAX_OUT   = 64;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] ST_LOAD_OK  = 2'd0;
	localparam logic [1:0] ST_PATH     = 2'd1;
	localparam logic [1:0] ST_NO_ROUTE = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [1:0]           action;
		logic [NODE_ID_W-1:0] source_node;
		logic [NODE_ID_W-1:0] target_node;
		logic [WEIGHT_W-1:0]  arc_length;
	} sps_req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [NODE_ID_W-1:0]  path_node;
		logic [OUT_DIST_W-1:0] path_distance;
		logic                  last;
	} sps_rsp_t;

	typedef struct packed {
		logic [NODE_ID_W-1:0] tail;
		logic [NODE_ID_W-1:0] head;
		logic [WEIGHT_W-1:0]  weight;
	} arc_t;

	typedef struct packed {
		logic clr;
		logic add;
	} arc_ctl_t;

endpackage
`default_nettype wire

// File: sv/sps_arc_store.sv
// sps_arc_store: arc memory with fill count and full flag.
// Depends on sps_pkg.
`default_nettype none
module sps_arc_store #(
	parameter int ARCS = 256,
	parameter int AW   = 8,
	parameter int CW   = 9
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sps_pkg::arc_ctl_t ctl,
	input  wire sps_pkg::arc_t     wr_arc,
	input  wire logic [AW-1:0]     rd_addr,
	output sps_pkg::arc_t          rd_arc,
	output logic [CW-1:0]          count,
	output logic                   full
);
	import sps_pkg::*;

	arc_t          mem [ARCS];
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(ARCS));
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clr) begin
			count_q <= '0;
		end else if (ctl.add && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add && !ctl.clr && !full) begin
			mem[count_q[AW-1:0]] <= wr_arc;
		end
		rd_arc <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// File: sv/sps_node_store.sv
// sps_node_store: per-node distance/predecessor memory and path stack memory.
// Depends on sps_pkg.
`default_nettype none
module sps_node_store #(
	parameter int NODES = 64,
	parameter int NW    = 6,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          node_we,
	input  wire logic [NW-1:0] node_waddr,
	input  wire logic [DW-1:0] node_wdist,
	input  wire logic [NW-1:0] node_wpred,
	input  wire logic [NW-1:0] node_raddr,
	output logic [DW-1:0]      node_rdist,
	output logic [NW-1:0]      node_rpred,
	input  wire logic          stk_we,
	input  wire logic [NW-1:0] stk_waddr,
	input  wire logic [NW-1:0] stk_wdata,
	input  wire logic [NW-1:0] stk_raddr,
	output logic [NW-1:0]      stk_rdata
);
	import sps_pkg::*;

	logic [DW+NW-1:0] node_mem [NODES];
	logic [NW-1:0]    stk_mem  [NODES];

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= {node_wdist, node_wpred};
		end
		{node_rdist, node_rpred} <= node_mem[node_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rdata <= stk_mem[stk_raddr];
	end

endmodule
`default_nettype wire

// File: sv/shortest_path_search.sv
// shortest_path_search: top level, search sequencer and result register.
// Depends on sps_pkg, sps_arc_store, sps_node_store.
//
// Input channel in_valid/in_ready/in_data carries one request: clear the arc
// store, add an arc, or query a path. Output channel out_valid/out_ready/
// out_data carries results; last marks the final result of a request.
// Clear and add each give one result; loads are taken every
// cycle as long as the result register drains.
// A query holds in_ready low while it runs. Each round scans all node
// entries through the node memory port and picks the next node, then
// walks the arc store and relaxes each arc leaving the settled node.
// The path is then traced back through the predecessors and emitted one
// node at a time, each node waiting for the result register to drain.
// Reset empties the arc store and the result register. While out_ready is
// low the result stays put and the block waits; no result is dropped.
`default_nettype none
module shortest_path_search #(
	parameter int NODES      = 64,
	parameter int ARCS       = 256,
	parameter int DIST_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sps_pkg::sps_req_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sps_pkg::sps_rsp_t      out_data
);
	import sps_pkg::*;

	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int AW = (ARCS > 1) ? $clog2(ARCS) : 1;
	localparam int CW = $clog2(ARCS + 1);
	localparam int DW = DIST_WIDTH;
	localparam int SW = ((DW > WEIGHT_W) ? DW : WEIGHT_W) + 1;
	localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_SCAN     = 11'b00000000010,
		S_SCAN_END = 11'b00000000100,
		S_DECIDE   = 11'b00000001000,
		S_ARC_RD   = 11'b00000010000,
		S_ARC_CHK  = 11'b00000100000,
		S_RELAX    = 11'b00001000000,
		S_WALK_CHK = 11'b00010000000,
		S_WALK_RD  = 11'b00100000000,
		S_EMIT_RD  = 11'b01000000000,
		S_EMIT_WR  = 11'b10000000000
	} state_t;

	state_t          state_q;
	logic [NW:0]     n_q;
	logic [NW-1:0]   n_s1;
	logic            v_s1;
	logic            found_q;
	logic [NW-1:0]   best_n_q;
	logic [DW-1:0]   best_d_q;
	logic [NW-1:0]   u_q;
	logic [DW-1:0]   du_q;
	logic [CW-1:0]   ai_q;
	logic [NW-1:0]   head_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [NODES-1:0] reached_q;
	logic [NODES-1:0] settled_q;
	logic [NW-1:0]   src_q;
	logic [NW-1:0]   dst_q;
	logic [DW-1:0]   dd_q;
	logic [NW-1:0]   cur_q;
	logic [NW-1:0]   len_q;
	logic [NW-1:0]   ptr_q;
	logic [6:0]      k_q;
	sps_rsp_t        out_q;
	logic            out_valid_q;

	arc_ctl_t        arc_ctl;
	arc_t            arc_wr, arc_rd;
	logic [AW-1:0]   arc_raddr;
	logic [CW-1:0]   arc_count;
	logic            arc_full;

	logic            node_we;
	logic [NW-1:0]   node_waddr, node_wpred, node_raddr, node_rpred;
	logic [DW-1:0]   node_wdist, node_rdist;
	logic            stk_we;
	logic [NW-1:0]   stk_waddr, stk_wdata, stk_rdata;

	logic            slot_free;
	logic            accept;
	logic            cand;
	logic [SW-1:0]   sum;
	logic [DW-1:0]   nd;
	logic            improve;
	logic            arc_use;
	logic            walk_more;
	logic            emit_last;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cand = v_s1 && reached_q[n_s1] && !settled_q[n_s1]
		&& (!found_q || node_rdist < best_d_q);
	assign sum  = SW'(du_q) + SW'(w_q);
	assign nd   = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DW-1:0];
	assign improve = !reached_q[head_q] || nd < node_rdist;
	assign arc_use = (32'(arc_rd.tail) == 32'(u_q)) && (32'(arc_rd.head) < NODES);
	assign walk_more = (cur_q != src_q) && (32'(len_q) < NODES - 1);
	assign emit_last = (ptr_q == '0) || (k_q == 7'(MAX_OUT - 1));

	assign arc_ctl.clr = accept && in_data.action == ACT_CLEAR;
	assign arc_ctl.add = accept && in_data.action == ACT_ADD;
	assign arc_wr.tail   = in_data.source_node;
	assign arc_wr.head   = in_data.target_node;
	assign arc_wr.weight = in_data.arc_length;
	assign arc_raddr     = ai_q[AW-1:0];

	always_comb begin
		node_we    = 1'b0;
		node_waddr = head_q;
		node_wdist = nd;
		node_wpred = u_q;
		node_raddr = n_q[NW-1:0];
		stk_we     = 1'b0;
		stk_waddr  = len_q;
		stk_wdata  = cur_q;
		unique case (state_q)
			S_IDLE: begin
				node_we    = accept && in_data.action == ACT_QUERY;
				node_waddr = NW'(in_data.source_node);
				node_wdist = '0;
			end
			S_ARC_CHK: node_raddr = NW'(arc_rd.head);
			S_RELAX:   node_we    = improve;
			S_WALK_CHK: begin
				node_raddr = cur_q;
				stk_we     = 1'b1;
				stk_wdata  = walk_more ? cur_q : src_q;
			end
			default: ;
		endcase
	end

	sps_arc_store #(.ARCS(ARCS), .AW(AW), .CW(CW)) u_arcs (
		.clk, .arst_n, .ctl(arc_ctl), .wr_arc(arc_wr), .rd_addr(arc_raddr),
		.rd_arc(arc_rd), .count(arc_count), .full(arc_full)
	);

	sps_node_store #(.NODES(NODES), .NW(NW), .DW(DW)) u_nodes (
		.clk, .node_we, .node_waddr, .node_wdist, .node_wpred, .node_raddr,
		.node_rdist, .node_rpred, .stk_we, .stk_waddr, .stk_wdata,
		.stk_raddr(ptr_q), .stk_rdata
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			found_q     <= 1'b0;
			reached_q   <= '0;
			settled_q   <= '0;
			n_q         <= '0;
			ai_q        <= '0;
			len_q       <= '0;
			ptr_q       <= '0;
			k_q         <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= (state_q == S_SCAN);
			n_s1 <= n_q[NW-1:0];
			if (cand) begin
				found_q  <= 1'b1;
				best_n_q <= n_s1;
				best_d_q <= node_rdist;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_q.path_node     <= '0;
						out_q.path_distance <= '0;
						out_q.last          <= 1'b1;
						src_q <= NW'(in_data.source_node);
						dst_q <= NW'(in_data.target_node);
						case (in_data.action)
							ACT_CLEAR: begin
								out_q.status <= ST_LOAD_OK;
								out_valid_q  <= 1'b1;
							end
							ACT_ADD: begin
								out_q.status <= arc_full ? ST_FULL : ST_LOAD_OK;
								out_valid_q  <= 1'b1;
							end
							ACT_QUERY: begin
								if (in_data.source_node == in_data.target_node) begin
									out_q.status    <= ST_PATH;
									out_q.path_node <= in_data.source_node;
									out_valid_q     <= 1'b1;
								end else if (32'(in_data.source_node) >= NODES
										|| 32'(in_data.target_node) >= NODES) begin
									out_q.status    <= ST_NO_ROUTE;
									out_q.path_node <= in_data.target_node;
									out_valid_q     <= 1'b1;
								end else begin
									reached_q <= NODES'(1) << NW'(in_data.source_node);
									settled_q <= '0;
									n_q       <= '0;
									found_q   <= 1'b0;
									state_q   <= S_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					n_q <= n_q + 1'b1;
					if (32'(n_q) == NODES - 1) begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (!found_q) begin
						if (slot_free) begin
							out_q.status        <= ST_NO_ROUTE;
							out_q.path_node     <= 6'(dst_q);
							out_q.path_distance <= '0;
							out_q.last          <= 1'b1;
							out_valid_q         <= 1'b1;
							state_q             <= S_IDLE;
						end
					end else begin
						settled_q[best_n_q] <= 1'b1;
						if (best_n_q == dst_q) begin
							dd_q    <= best_d_q;
							cur_q   <= dst_q;
							len_q   <= '0;
							state_q <= S_WALK_CHK;
						end else begin
							u_q     <= best_n_q;
							du_q    <= best_d_q;
							ai_q    <= '0;
							state_q <= S_ARC_RD;
						end
					end
				end
				S_ARC_RD: begin
					if (ai_q >= arc_count) begin
						n_q     <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_ARC_CHK;
					end
				end
				S_ARC_CHK: begin
					head_q <= NW'(arc_rd.head);
					w_q    <= arc_rd.weight;
					if (arc_use) begin
						state_q <= S_RELAX;
					end else begin
						ai_q    <= ai_q + 1'b1;
						state_q <= S_ARC_RD;
					end
				end
				S_RELAX: begin
					if (improve) begin
						reached_q[head_q] <= 1'b1;
					end
					ai_q    <= ai_q + 1'b1;
					state_q <= S_ARC_RD;
				end
				S_WALK_CHK: begin
					if (walk_more) begin
						len_q   <= len_q + 1'b1;
						state_q <= S_WALK_RD;
					end else begin
						ptr_q   <= len_q;
						k_q     <= '0;
						state_q <= S_EMIT_RD;
					end
				end
				S_WALK_RD: begin
					cur_q   <= node_rpred;
					state_q <= S_WALK_CHK;
				end
				S_EMIT_RD: state_q <= S_EMIT_WR;
				S_EMIT_WR: begin
					if (slot_free) begin
						out_q.status        <= ST_PATH;
						out_q.path_node     <= 6'(stk_rdata);
						out_q.path_distance <= 32'(dd_q);
						out_q.last          <= emit_last;
						out_valid_q         <= 1'b1;
						if (emit_last) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q   <= ptr_q - 1'b1;
							k_q     <= k_q + 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/sps_checker.sv
// sps_checker: port-level checks on shortest_path_search, bound to the top.
// Depends on sps_pkg.
`default_nettype none
module sps_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire sps_pkg::sps_req_t in_data,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire sps_pkg::sps_rsp_t out_data
);
	import sps_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid && !out_ready))
		else $error("request taken while result blocked");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.action == ACT_CLEAR || in_data.action == ACT_ADD)
		|=> out_valid && out_data.last
			&& (out_data.status == ST_LOAD_OK || out_data.status == ST_FULL))
		else $error("load result missing");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_PATH |-> out_data.last)
		else $error("non-path result without last");

endmodule

bind shortest_path_search sps_checker u_sps_checker (.*);
`default_nettype wire

// File: bench/shortest_path_search_tb.sv
// shortest_path_search_tb: self-checking bench for the shortest path search block.
// Depends on sps_pkg and shortest_path_search. A scoreboard class keeps its own
// arc store, predicts every result and checks them in order.
`default_nettype none
module shortest_path_search_tb;
	import sps_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int NODE_CNT  = 64;
	localparam int ARC_CAP   = 256;
	localparam longint unsigned DIST_SAT = 64'hFFFF_FFFF;
	localparam int IDLE_LIMIT = 300000;

	class route_scoreboard;
		logic [5:0]  tail_q[ARC_CAP];
		logic [5:0]  head_q[ARC_CAP];
		logic [23:0] weight_q[ARC_CAP];
		int          arc_total;
		sps_rsp_t    pending[$];
		int          errors;

		function new();
			arc_total = 0;
			errors = 0;
		endfunction

		function void push_rsp(logic [1:0] st, logic [5:0] node, logic [31:0] span,
				logic lst);
			sps_rsp_t r;
			r.status = st;
			r.path_node = node;
			r.path_distance = span;
			r.last = lst;
			pending.insert(pending.size(), r);
		endfunction

		function void search(logic [5:0] src, logic [5:0] dst);
			longint unsigned cost[NODE_CNT];
			bit          seen[NODE_CNT];
			bit          done[NODE_CNT];
			logic [5:0]  prev[NODE_CNT];
			logic [5:0]  trail[NODE_CNT];
			int          u, len, cur;
			bit          found;
			longint unsigned nd;
			if (src == dst) begin
				push_rsp(ST_PATH, src, 32'd0, 1'b1);
				return;
			end
			for (int i = 0; i < NODE_CNT; i++) begin
				cost[i] = DIST_SAT;
				seen[i] = 0;
				done[i] = 0;
			end
			cost[src] = 0;
			seen[src] = 1;
			forever begin
				found = 0;
				u = 0;
				for (int n = 0; n < NODE_CNT; n++)
					if (seen[n] && !done[n] && (!found || cost[n] < cost[u])) begin
						u = n;
						found = 1;
					end
				if (!found)
					break;
				done[u] = 1;
				if (6'(u) == dst)
					break;
				for (int i = 0; i < arc_total; i++) begin
					if (int'(tail_q[i]) != u)
						continue;
					nd = cost[u] + 64'(weight_q[i]);
					if (nd > DIST_SAT)
						nd = DIST_SAT;
					if (!seen[head_q[i]] || nd < cost[head_q[i]]) begin
						cost[head_q[i]] = nd;
						prev[head_q[i]] = 6'(u);
						seen[head_q[i]] = 1;
					end
				end
			end
			if (!seen[dst]) begin
				push_rsp(ST_NO_ROUTE, dst, 32'd0, 1'b1);
				return;
			end
			len = 0;
			cur = int'(dst);
			while (cur != int'(src) && len < NODE_CNT - 1) begin
				trail[len] = 6'(cur);
				len++;
				cur = int'(prev[cur]);
			end
			trail[len] = src;
			len++;
			for (int k = 0; len > 0 && k < MAX_OUT; k++) begin
				len--;
				push_rsp(ST_PATH, trail[len], cost[dst][31:0],
					(len == 0 || k == MAX_OUT - 1));
			end
		endfunction

		function void note_request(sps_req_t req);
			case (req.action)
			ACT_CLEAR: begin
				arc_total = 0;
				push_rsp(ST_LOAD_OK, 6'd0, 32'd0, 1'b1);
			end
			ACT_ADD: begin
				if (arc_total >= ARC_CAP)
					push_rsp(ST_FULL, 6'd0, 32'd0, 1'b1);
				else begin
					tail_q[arc_total] = req.source_node;
					head_q[arc_total] = req.target_node;
					weight_q[arc_total] = req.arc_length;
					arc_total++;
					push_rsp(ST_LOAD_OK, 6'd0, 32'd0, 1'b1);
				end
			end
			ACT_QUERY: search(req.source_node, req.target_node);
			default: ;
			endcase
		endfunction

		function void check_result(sps_rsp_t got);
			sps_rsp_t want;
			if (pending.size() == 0) begin
				$display("%0t unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.path_node !== want.path_node ||
					got.path_distance !== want.path_distance || got.last !== want.last) begin
				$display("%0t mismatch expected %p actual %p", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	sps_req_t in_data;
	logic     out_valid;
	logic     out_ready;
	sps_rsp_t out_data;

	route_scoreboard sb;
	bit  steady;
	bit  long_hold;
	bit  stim_done;
	int  idle_cycles;

	shortest_path_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(logic [1:0] act, logic [5:0] src, logic [5:0] dst,
			logic [23:0] len);
		int gap;
		in_valid <= 1'b1;
		in_data <= '{action: act, source_node: src, target_node: dst, arc_length: len};
		do @(posedge clk); while (!in_ready);
		sb.note_request(in_data);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function logic [23:0] pick_weight();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 24'd0;
		if (r == 1)
			return 24'hFFFFFF;
		if (r == 2)
			return 24'($urandom);
		return 24'($urandom_range(1, 50));
	endfunction

	// receiver: random back-pressure, one long hold on request
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 0;
			end
			out_ready <= steady ? 1'b1 : ($urandom_range(0, 9) < 7);
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	// watchdog on cycles with no transfer on either side
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [5:0] base, a, b;
		int n_arcs, sent;
		sb = new();
		in_valid <= 1'b0;
		in_data <= '0;
		steady = 0;
		long_hold = 0;
		stim_done = 0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(ACT_QUERY, 6'd5, 6'd5, 24'd0);
		send(ACT_QUERY, 6'd0, 6'd63, 24'hFFFFFF);
		send(ACT_CLEAR, 6'd63, 6'd63, 24'hFFFFFF);
		send(ACT_ADD, 6'd0, 6'd1, 24'd0);
		send(ACT_ADD, 6'd1, 6'd63, 24'hFFFFFF);
		send(ACT_ADD, 6'd0, 6'd2, 24'd10);
		send(ACT_ADD, 6'd2, 6'd63, 24'hFFFFF0);
		send(ACT_ADD, 6'd0, 6'd3, 24'd5);
		send(ACT_ADD, 6'd3, 6'd1, 24'd0);
		send(ACT_ADD, 6'd63, 6'd42, 24'hFFFFFF);
		send(ACT_UNUSED, 6'd42, 6'd21, 24'h5A5A5A);
		send(ACT_QUERY, 6'd0, 6'd63, 24'd0);
		send(ACT_QUERY, 6'd0, 6'd42, 24'd0);
		send(ACT_QUERY, 6'd42, 6'd0, 24'd0);
		send(ACT_QUERY, 6'd63, 6'd63, 24'd0);
		drain();

		// fill the arc store while the receiver holds off, then overflow
		send(ACT_CLEAR, 6'd0, 6'd0, 24'd0);
		long_hold = 1;
		steady = 1;
		for (int i = 0; i < ARC_CAP + 2; i++) begin
			a = 6'($urandom_range(0, 63));
			b = 6'($urandom_range(0, 63));
			send(ACT_ADD, a, b, pick_weight());
		end
		steady = 0;
		send(ACT_QUERY, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 24'd0);
		send(ACT_QUERY, 6'd0, 6'd63, 24'd0);
		drain();

		// random graphs on small node pools, mostly well-formed sequences
		sent = 0;
		while (sent < 40) begin
			steady = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) < 8) begin
				send(ACT_CLEAR, 6'($urandom), 6'($urandom), 24'($urandom));
				sent++;
			end
			base = 6'($urandom_range(0, 63));
			n_arcs = $urandom_range(1, 14);
			for (int i = 0; i < n_arcs; i++) begin
				a = base + 6'($urandom_range(0, 7));
				b = base + 6'($urandom_range(0, 7));
				send(ACT_ADD, a, b, pick_weight());
				sent++;
			end
			for (int i = $urandom_range(1, 3); i > 0; i--) begin
				a = ($urandom_range(0, 9) == 0) ? 6'($urandom)
					: base + 6'($urandom_range(0, 7));
				b = ($urandom_range(0, 9) == 0) ? 6'($urandom)
					: base + 6'($urandom_range(0, 7));
				send(ACT_QUERY, a, b, 24'($urandom));
				sent++;
			end
			if ($urandom_range(0, 7) == 0)
				send(ACT_UNUSED, 6'($urandom), 6'($urandom), 24'($urandom));
			if ($urandom_range(0, 9) == 0)
				drain();
		end
		steady = 0;
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
